// ===== design/dfac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfac_pkg;

    // Time base
    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] time_t;

    localparam time_t EVAL_PERIOD_MS = time_t'(300);
    localparam time_t TEMP_PERIOD_MS = time_t'(2000);
    localparam time_t PULSE_HIGH_MS  = time_t'(200);
    localparam time_t PULSE_LOW_MS   = time_t'(100);

    // Vote totals
    localparam logic [7:0] LIGHT_VOTES = 8'd20;
    localparam logic [7:0] SMOKE_VOTES = 8'd10;

    // Temperature limits, sixteenths of a degree
    localparam logic signed [11:0] TEMP_MIN_RAW = -12'sd880;
    localparam logic signed [11:0] TEMP_MAX_RAW = 12'sd2000;
    localparam logic signed [12:0] INVALID_TEMP = -13'sd2032;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP_THRESHOLD   = 3'd0,
        REG_TEMP_OFFSET      = 3'd1,
        REG_DARK_MIN_VOTES   = 3'd2,
        REG_SMOKE_MIN_VOTES  = 3'd3,
        REG_LIGHT_HOLDOFF    = 3'd4,
        REG_SMOKE_HOLDOFF    = 3'd5,
        REG_HEAT_HOLDOFF     = 3'd6,
        REG_BUZZ_PULSE_TOTAL = 3'd7
    } cfg_reg_e;

    // Status code, by priority
    typedef enum logic [2:0] {
        STATUS_FIRE  = 3'd0,
        STATUS_SMOKE = 3'd1,
        STATUS_HEAT  = 3'd2,
        STATUS_DARK  = 3'd3,
        STATUS_CLEAR = 3'd4
    } status_e;

    // Input beat, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic               temp_present;
        logic signed [11:0] temp_raw;
        logic [3:0]         smoke_low_count;
        logic [4:0]         light_high_count;
        logic [31:0]        now_ms;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic               pad;
        logic               pulses_done;
        status_e            status_code;
        logic signed [12:0] temp_now;
        logic               sensor_good;
        logic               fire_flag;
        logic               heat_flag;
        logic               smoke_flag;
        logic               buzzer_on;
        logic               lamp_on;
    } res_beat_t;

    // Top level to buzzer sequencer
    typedef struct packed {
        logic step;   // a loop pass is being retired
        logic start;  // fire raised on this pass
        logic clear;  // fire dropped on this pass
    } buzz_ctrl_t;

    typedef struct packed {
        logic running;
        logic phase;
        logic done;
    } buzz_stat_t;

    function automatic time_t elapsed(input time_t now, input time_t then);
        return now - then;
    endfunction

endpackage

`default_nettype wire

// ===== design/dfac_buzzer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfac_buzzer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dfac_pkg::buzz_ctrl_t ctrl,
    input  wire dfac_pkg::time_t     now,
    input  wire logic [3:0]          pulse_total,
    output dfac_pkg::buzz_stat_t     stat,
    output dfac_pkg::buzz_stat_t     stat_next
);
    import dfac_pkg::*;

    logic       running_reg, running_next;
    logic       phase_reg, phase_next;
    logic       done_reg, done_next;
    logic [3:0] count_reg, count_next;
    time_t      toggle_reg, toggle_next;

    time_t      wait_ms;
    logic [3:0] count_inc;

    always_comb begin
        running_next = running_reg;
        phase_next   = phase_reg;
        done_next    = done_reg;
        count_next   = count_reg;
        toggle_next  = toggle_reg;
        wait_ms      = phase_reg ? PULSE_HIGH_MS : PULSE_LOW_MS;
        count_inc    = count_reg + 4'd1;

        if (ctrl.step) begin
            priority if (ctrl.clear) begin
                running_next = 1'b0;
                phase_next   = 1'b0;
                done_next    = 1'b0;
                count_next   = '0;
                toggle_next  = '0;
            end else if (ctrl.start && !running_reg) begin
                running_next = 1'b1;
                phase_next   = 1'b0;
                done_next    = 1'b0;
                count_next   = '0;
                toggle_next  = now;
            end else if (running_reg && !done_reg && elapsed(now, toggle_reg) >= wait_ms) begin
                // falling edge of the pin closes one pulse
                toggle_next = now;
                phase_next  = !phase_reg;
                if (phase_reg) begin
                    count_next = count_inc;
                    if (count_inc >= pulse_total) begin
                        done_next = 1'b1;
                    end
                end
            end else begin
                // idle, finished, or still inside the current phase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            phase_reg   <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            toggle_reg  <= '0;
        end else begin
            running_reg <= running_next;
            phase_reg   <= phase_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
            toggle_reg  <= toggle_next;
        end
    end

    assign stat      = '{running: running_reg, phase: phase_reg, done: done_reg};
    assign stat_next = '{running: running_next, phase: phase_next, done: done_next};

    a_done_needs_running: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> running_reg)
        else $error("train done without a running alarm");

    a_phase_needs_running: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> running_reg)
        else $error("buzzer phase high with no alarm");

    a_start_clears_train: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && ctrl.start && !ctrl.clear && !running_reg)
        |=> (running_reg && !phase_reg && !done_reg && count_reg == 4'd0))
        else $error("alarm start did not reset the pulse train");

endmodule

`default_nettype wire

// ===== design/debounced_fire_alarm_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounced fire alarm controller.
// Each input beat on s_* is one pass of the control loop: a millisecond
// timestamp, light and smoke vote counts and one temperature sample.
// Every pass yields exactly one result beat on m_*: lamp, buzzer pin,
// debounced smoke/heat/fire flags, sensor status, stored temperature,
// status code and the pulse-train-done flag.
// Pipeline: input register -> flag/buzzer update -> result register.
// One beat per cycle is sustained while m_tready stays high. The state
// update is a single pass of compares and subtracts on the input
// register, so nothing loops back over cycles. When m_tready is low the
// result register holds its beat; one more beat is still taken into the
// input register, after which s_tready drops. The user must see that
// configuration (cfg_we/cfg_index/cfg_wdata) is written only while no
// beat is in flight; the block does not enforce this. A write takes
// effect at the next clock edge. Synchronous reset (aresetn low) empties
// both stages, clears all flags, timers and the buzzer train, and loads
// the register defaults: threshold 960, offset 208, votes 5/7, hold-offs
// 2000/3000/5000 ms, 5 buzzer pulses.
module debounced_fire_alarm_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // now_ms[31:0], light_high_count[36:32], smoke_low_count[40:37],
    // temp_raw[52:41], temp_present[53], zero pad[55:54]
    input  wire logic [55:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // lamp_on[0], buzzer_on[1], smoke_flag[2], heat_flag[3], fire_flag[4],
    // sensor_good[5], temp_now[18:6], status_code[21:19],
    // pulses_done[22], zero pad[23]
    output logic [23:0]      m_tdata
);
    import dfac_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [11:0] temp_threshold_reg;
    logic [9:0]         temp_offset_reg;
    logic [4:0]         dark_min_votes_reg;
    logic [3:0]         smoke_min_votes_reg;
    logic [15:0]        light_holdoff_reg;
    logic [15:0]        smoke_holdoff_reg;
    logic [15:0]        heat_holdoff_reg;
    logic [3:0]         buzz_pulse_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_threshold_reg   <= 12'sd960;
            temp_offset_reg      <= 10'd208;
            dark_min_votes_reg   <= 5'd5;
            smoke_min_votes_reg  <= 4'd7;
            light_holdoff_reg    <= 16'd2000;
            smoke_holdoff_reg    <= 16'd3000;
            heat_holdoff_reg     <= 16'd5000;
            buzz_pulse_total_reg <= 4'd5;
        end else if (cfg_we) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_TEMP_THRESHOLD:   temp_threshold_reg   <= signed'(cfg_wdata[11:0]);
                REG_TEMP_OFFSET:      temp_offset_reg      <= cfg_wdata[9:0];
                REG_DARK_MIN_VOTES:   dark_min_votes_reg   <= cfg_wdata[4:0];
                REG_SMOKE_MIN_VOTES:  smoke_min_votes_reg  <= cfg_wdata[3:0];
                REG_LIGHT_HOLDOFF:    light_holdoff_reg    <= cfg_wdata;
                REG_SMOKE_HOLDOFF:    smoke_holdoff_reg    <= cfg_wdata;
                REG_HEAT_HOLDOFF:     heat_holdoff_reg     <= cfg_wdata;
                REG_BUZZ_PULSE_TOTAL: buzz_pulse_total_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic     in_valid_reg;
    in_beat_t in_beat_reg;
    logic     m_valid_reg;
    res_beat_t res_reg, res_next;
    logic     advance;
    logic     step;

    assign advance  = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_beat_reg <= in_beat_t'(s_tdata);
        end
    end

    // ---------------- loop state ----------------
    logic               dark_state_reg, dark_state_next;
    logic               smoke_state_reg, smoke_state_next;
    logic               heat_state_reg, heat_state_next;
    logic               fire_state_reg, fire_state_next;
    logic               sensor_valid_reg, sensor_valid_next;
    logic signed [12:0] temp_store_reg, temp_store_next;
    time_t              last_eval_reg, last_eval_next;
    time_t              last_temp_reg, last_temp_next;
    time_t              last_dark_reg, last_dark_next;
    time_t              last_smoke_reg, last_smoke_next;
    time_t              last_heat_reg, last_heat_next;

    time_t              now;
    logic               eval_due;
    logic               temp_due;
    logic [7:0]         light_cnt;
    logic [7:0]         smoke_cnt;
    logic               dark_vote;
    logic               smoke_vote;
    logic               raw_ok;
    logic signed [12:0] temp_adj;
    logic               hot;
    logic               danger;
    buzz_ctrl_t         buzz_ctrl;
    buzz_stat_t         buzz_stat;
    buzz_stat_t         buzz_stat_next;

    assign now = time_t'(in_beat_reg.now_ms);

    always_comb begin
        dark_state_next   = dark_state_reg;
        smoke_state_next  = smoke_state_reg;
        heat_state_next   = heat_state_reg;
        fire_state_next   = fire_state_reg;
        sensor_valid_next = sensor_valid_reg;
        temp_store_next   = temp_store_reg;
        last_eval_next    = last_eval_reg;
        last_temp_next    = last_temp_reg;
        last_dark_next    = last_dark_reg;
        last_smoke_next   = last_smoke_reg;
        last_heat_next    = last_heat_reg;
        buzz_ctrl         = '{step: step, start: 1'b0, clear: 1'b0};

        eval_due = elapsed(now, last_eval_reg) >= EVAL_PERIOD_MS;
        temp_due = elapsed(now, last_temp_reg) > TEMP_PERIOD_MS;

        // votes above the total count as the total
        light_cnt = {3'b000, in_beat_reg.light_high_count};
        smoke_cnt = {4'b0000, in_beat_reg.smoke_low_count};
        if (light_cnt > LIGHT_VOTES) light_cnt = LIGHT_VOTES;
        if (smoke_cnt > SMOKE_VOTES) smoke_cnt = SMOKE_VOTES;
        dark_vote  = light_cnt >= {3'b000, dark_min_votes_reg};
        smoke_vote = smoke_cnt >= {4'b0000, smoke_min_votes_reg};

        raw_ok   = in_beat_reg.temp_present
                   && in_beat_reg.temp_raw >= TEMP_MIN_RAW
                   && in_beat_reg.temp_raw <= TEMP_MAX_RAW;
        temp_adj = 13'(in_beat_reg.temp_raw) - signed'({3'b000, temp_offset_reg});

        if (eval_due) begin
            last_eval_next = now;
            if (temp_due) begin
                sensor_valid_next = raw_ok;
                temp_store_next   = raw_ok ? temp_adj : INVALID_TEMP;
                last_temp_next    = now;
            end
        end

        hot = sensor_valid_next && (temp_store_next > 13'(temp_threshold_reg));

        if (eval_due) begin
            // each flag moves only once its hold-off has run out
            if (dark_vote != dark_state_reg
                && elapsed(now, last_dark_reg) > time_t'(light_holdoff_reg)) begin
                dark_state_next = dark_vote;
                last_dark_next  = now;
            end
            if (smoke_vote != smoke_state_reg
                && elapsed(now, last_smoke_reg) > time_t'(smoke_holdoff_reg)) begin
                smoke_state_next = smoke_vote;
                last_smoke_next  = now;
            end
            if (hot != heat_state_reg
                && elapsed(now, last_heat_reg) > time_t'(heat_holdoff_reg)) begin
                heat_state_next = hot;
                last_heat_next  = now;
            end
        end

        danger = smoke_state_next || heat_state_next;
        if (eval_due) begin
            if (danger && !fire_state_reg) begin
                fire_state_next = 1'b1;
                buzz_ctrl.start = 1'b1;
            end else if (!danger && fire_state_reg) begin
                fire_state_next = 1'b0;
                buzz_ctrl.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_state_reg   <= 1'b0;
            smoke_state_reg  <= 1'b0;
            heat_state_reg   <= 1'b0;
            fire_state_reg   <= 1'b0;
            sensor_valid_reg <= 1'b0;
            temp_store_reg   <= '0;
            last_eval_reg    <= '0;
            last_temp_reg    <= '0;
            last_dark_reg    <= '0;
            last_smoke_reg   <= '0;
            last_heat_reg    <= '0;
        end else if (step) begin
            dark_state_reg   <= dark_state_next;
            smoke_state_reg  <= smoke_state_next;
            heat_state_reg   <= heat_state_next;
            fire_state_reg   <= fire_state_next;
            sensor_valid_reg <= sensor_valid_next;
            temp_store_reg   <= temp_store_next;
            last_eval_reg    <= last_eval_next;
            last_temp_reg    <= last_temp_next;
            last_dark_reg    <= last_dark_next;
            last_smoke_reg   <= last_smoke_next;
            last_heat_reg    <= last_heat_next;
        end
    end

    // ---------------- buzzer pulse train ----------------
    dfac_buzzer u_buzzer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (buzz_ctrl),
        .now         (now),
        .pulse_total (buzz_pulse_total_reg),
        .stat        (buzz_stat),
        .stat_next   (buzz_stat_next)
    );

    // ---------------- result beat ----------------
    always_comb begin
        res_next.pad         = 1'b0;
        res_next.lamp_on     = dark_state_next;
        res_next.buzzer_on   = buzz_stat_next.done || buzz_stat_next.phase;
        res_next.smoke_flag  = smoke_state_next;
        res_next.heat_flag   = heat_state_next;
        res_next.fire_flag   = fire_state_next;
        res_next.sensor_good = sensor_valid_next;
        res_next.temp_now    = temp_store_next;
        res_next.pulses_done = buzz_stat_next.done;
        priority if (fire_state_next)  res_next.status_code = STATUS_FIRE;
        else if (smoke_state_next)     res_next.status_code = STATUS_SMOKE;
        else if (heat_state_next)      res_next.status_code = STATUS_HEAT;
        else if (dark_state_next)      res_next.status_code = STATUS_DARK;
        else                           res_next.status_code = STATUS_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    // ---------------- checks ----------------
    a_fire_tracks_danger: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_state_reg == (smoke_state_reg || heat_state_reg))
        else $error("fire flag out of step with smoke/heat");

    a_alarm_tracks_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        buzz_stat.running == fire_state_reg)
        else $error("buzzer train running without fire, or the reverse");

    a_invalid_temp_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        !sensor_valid_reg |-> (temp_store_reg == INVALID_TEMP || temp_store_reg == 13'sd0))
        else $error("invalid sensor with a real temperature stored");

    a_stalled_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input beat dropped while output stalled");

endmodule

`default_nettype wire

// ===== bench/alarm_pass_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port, keeps its own copy of the
// alarm state, and checks every result beat against the oldest prediction.
module alarm_pass_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          fire_results,
    output int          train_results
);
    import dfac_pkg::*;

    localparam logic [31:0] EVAL_MS  = 32'd300;
    localparam logic [31:0] TEMP_MS  = 32'd2000;
    localparam logic [31:0] ON_MS    = 32'd200;
    localparam logic [31:0] OFF_MS   = 32'd100;
    localparam int          RAW_MIN  = -880;
    localparam int          RAW_MAX  = 2000;
    localparam logic signed [12:0] TEMP_BAD = -13'sd2032;
    localparam logic [4:0]  LIGHT_MAX = 5'd20;
    localparam logic [3:0]  SMOKE_MAX = 4'd10;

    // register copy
    logic signed [11:0] thr;
    logic [9:0]         offset;
    logic [4:0]         dark_votes;
    logic [3:0]         smoke_votes;
    logic [15:0]        light_hold, smoke_hold, heat_hold;
    logic [3:0]         pulse_total;

    // alarm state
    logic               dark_st, smoke_st, heat_st, fire_st, valid_st;
    logic signed [12:0] temp_q;
    logic [31:0]        eval_ms, read_ms, dark_chg_ms, smoke_chg_ms, heat_chg_ms;
    logic               buzz_run, buzz_hi, train_end;
    logic [3:0]         pulse_cnt;
    logic [31:0]        toggle_ms;

    res_beat_t          alarm_q[$];

    function automatic void clear_train();
        buzz_run  = 1'b0;
        buzz_hi   = 1'b0;
        train_end = 1'b0;
        pulse_cnt = '0;
        toggle_ms = '0;
    endfunction

    function automatic void reset_model();
        thr         = 12'sd960;
        offset      = 10'd208;
        dark_votes  = 5'd5;
        smoke_votes = 4'd7;
        light_hold  = 16'd2000;
        smoke_hold  = 16'd3000;
        heat_hold   = 16'd5000;
        pulse_total = 4'd5;
        dark_st = 1'b0; smoke_st = 1'b0; heat_st = 1'b0; fire_st = 1'b0;
        valid_st = 1'b0;
        temp_q = '0;
        eval_ms = '0; read_ms = '0;
        dark_chg_ms = '0; smoke_chg_ms = '0; heat_chg_ms = '0;
        clear_train();
    endfunction

    // One pass of the control loop: evaluation (rate limited), then a buzzer tick.
    function automatic res_beat_t run_loop_pass(input in_beat_t b);
        logic [31:0]        now;
        logic [4:0]         lc;
        logic [3:0]         sc;
        logic signed [11:0] raw;
        logic               want_dark, want_smoke, want_hot, danger;
        logic [31:0]        wait_ms;
        res_beat_t          r;
        now = b.now_ms;
        if (now - eval_ms >= EVAL_MS) begin
            eval_ms = now;
            lc = (b.light_high_count > LIGHT_MAX) ? LIGHT_MAX : b.light_high_count;
            sc = (b.smoke_low_count > SMOKE_MAX) ? SMOKE_MAX : b.smoke_low_count;
            want_dark  = lc >= dark_votes;
            want_smoke = sc >= smoke_votes;
            if (now - read_ms > TEMP_MS) begin
                raw = b.temp_raw;
                if (b.temp_present && int'(raw) >= RAW_MIN && int'(raw) <= RAW_MAX) begin
                    valid_st = 1'b1;
                    temp_q   = 13'(int'(raw) - int'(offset));
                end else begin
                    valid_st = 1'b0;
                    temp_q   = TEMP_BAD;
                end
                read_ms = now;
            end
            want_hot = valid_st && (temp_q > thr);
            if (want_dark != dark_st && now - dark_chg_ms > light_hold) begin
                dark_st = want_dark;
                dark_chg_ms = now;
            end
            if (want_smoke != smoke_st && now - smoke_chg_ms > smoke_hold) begin
                smoke_st = want_smoke;
                smoke_chg_ms = now;
            end
            if (want_hot != heat_st && now - heat_chg_ms > heat_hold) begin
                heat_st = want_hot;
                heat_chg_ms = now;
            end
            danger = smoke_st || heat_st;
            if (danger && !fire_st) begin
                fire_st = 1'b1;
                if (!buzz_run) begin
                    clear_train();
                    buzz_run  = 1'b1;
                    toggle_ms = now;
                end
            end else if (!danger && fire_st) begin
                fire_st = 1'b0;
                clear_train();
            end
        end
        if (buzz_run && !train_end) begin
            wait_ms = buzz_hi ? ON_MS : OFF_MS;
            if (now - toggle_ms >= wait_ms) begin
                toggle_ms = now;
                buzz_hi   = !buzz_hi;
                if (!buzz_hi) begin
                    pulse_cnt = pulse_cnt + 4'd1;
                    if (pulse_cnt >= pulse_total) train_end = 1'b1;
                end
            end
        end
        r = '0;
        r.lamp_on     = dark_st;
        r.buzzer_on   = train_end || buzz_hi;
        r.smoke_flag  = smoke_st;
        r.heat_flag   = heat_st;
        r.fire_flag   = fire_st;
        r.sensor_good = valid_st;
        r.temp_now    = temp_q;
        r.status_code = fire_st  ? STATUS_FIRE  :
                        smoke_st ? STATUS_SMOKE :
                        heat_st  ? STATUS_HEAT  :
                        dark_st  ? STATUS_DARK  : STATUS_CLEAR;
        r.pulses_done = train_end;
        return r;
    endfunction

    function automatic void write_reg(input logic [2:0] idx, input logic [15:0] val);
        case (cfg_reg_e'(idx))
            REG_TEMP_THRESHOLD:   thr         = val[11:0];
            REG_TEMP_OFFSET:      offset      = val[9:0];
            REG_DARK_MIN_VOTES:   dark_votes  = val[4:0];
            REG_SMOKE_MIN_VOTES:  smoke_votes = val[3:0];
            REG_LIGHT_HOLDOFF:    light_hold  = val;
            REG_SMOKE_HOLDOFF:    smoke_hold  = val;
            REG_HEAT_HOLDOFF:     heat_hold   = val;
            REG_BUZZ_PULSE_TOTAL: pulse_total = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (mismatches < 10)
                $display("mismatch on %s in result %0d: expected %0d, got %0d",
                         name, results_seen, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        res_beat_t got, want;
        if (!aresetn) begin
            reset_model();
            alarm_q.delete();
            mismatches    = 0;
            results_seen  = 0;
            fire_results  = 0;
            train_results = 0;
        end else begin
            // retire first so a beat never meets its own prediction
            if (m_tvalid && m_tready) begin
                got = res_beat_t'(m_tdata);
                results_seen++;
                if (alarm_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("result beat %h with nothing expected", m_tdata);
                    mismatches++;
                end else begin
                    want = alarm_q.pop_front();
                    if (want.fire_flag) fire_results++;
                    if (want.pulses_done) train_results++;
                    check_field("lamp_on",     want.lamp_on,     got.lamp_on);
                    check_field("buzzer_on",   want.buzzer_on,   got.buzzer_on);
                    check_field("smoke_flag",  want.smoke_flag,  got.smoke_flag);
                    check_field("heat_flag",   want.heat_flag,   got.heat_flag);
                    check_field("fire_flag",   want.fire_flag,   got.fire_flag);
                    check_field("sensor_good", want.sensor_good, got.sensor_good);
                    check_field("temp_now",    int'(want.temp_now), int'(got.temp_now));
                    check_field("status_code", int'(want.status_code), int'(got.status_code));
                    check_field("pulses_done", want.pulses_done, got.pulses_done);
                end
            end
            if (s_tvalid && s_tready)
                alarm_q.push_back(run_loop_pass(in_beat_t'(s_tdata)));
            if (cfg_we)
                write_reg(cfg_index, cfg_wdata);
        end
        pending = alarm_q.size();
    end

endmodule

// ===== bench/tb_debounced_fire_alarm_controller.sv =====
`timescale 1ns / 1ps

module tb_debounced_fire_alarm_controller;
    import dfac_pkg::*;

    // hold-off of the result side used to back the block up
    localparam int LONG_HOLD   = 60;
    // cycles let pass after the last result
    localparam int SETTLE      = 4;
    localparam int DRAIN_LIMIT = 5000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // now_ms, light_high_count, smoke_low_count, temp_raw, temp_present, pad
    logic [55:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // lamp_on, buzzer_on, smoke/heat/fire flags, sensor_good, temp_now,
    // status_code, pulses_done, pad
    logic [23:0] m_tdata;

    int chk_mismatches, chk_pending, chk_results, chk_fire, chk_train;

    // idling controls, flipped per phase by the stimulus
    bit feed_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit hold_pending = 1'b0;

    // running clock of the loop passes and the current sensor "scene"
    logic [31:0] clock_ms;
    int          scene_left  = 0;
    int          scene_light, scene_smoke, scene_temp;
    int          passes_sent = 0;
    int          settings_used = 1;

    debounced_fire_alarm_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    alarm_pass_checker watch (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (chk_mismatches),
        .pending       (chk_pending),
        .results_seen  (chk_results),
        .fire_results  (chk_fire),
        .train_results (chk_train)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall before each beat, or a long hold-off when
    // the stimulus asks for one. Changes land on the falling edge.
    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = sink_gaps_on ? $urandom_range(0, 15) : 0;
            if (hold_pending) begin
                gap = LONG_HOLD;
                hold_pending = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    function automatic in_beat_t pass_beat(input logic [31:0] now, input int light,
                                           input int smoke, input int raw,
                                           input logic present);
        in_beat_t b;
        b = '0;
        b.now_ms           = now;
        b.light_high_count = 5'(light);
        b.smoke_low_count  = 4'(smoke);
        b.temp_raw         = 12'(raw);
        b.temp_present     = present;
        return b;
    endfunction

    // Offer one beat after a random gap; valid stays up into the next call
    // when that one draws no gap.
    task automatic send(input in_beat_t b);
        int gap;
        gap = feed_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        passes_sent++;
    endtask

    // Stop offering and wait for every predicted beat to come out.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 16'(val);
        @(negedge aclk);
    endtask

    // back-to-back writes of all eight registers; only called while idle
    task automatic program_regs(input int thr, input int off, input int dark_v,
                                input int smoke_v, input int light_h, input int smoke_h,
                                input int heat_h, input int pulses);
        write_reg(REG_TEMP_THRESHOLD,   thr);
        write_reg(REG_TEMP_OFFSET,      off);
        write_reg(REG_DARK_MIN_VOTES,   dark_v);
        write_reg(REG_SMOKE_MIN_VOTES,  smoke_v);
        write_reg(REG_LIGHT_HOLDOFF,    light_h);
        write_reg(REG_SMOKE_HOLDOFF,    smoke_h);
        write_reg(REG_HEAT_HOLDOFF,     heat_h);
        write_reg(REG_BUZZ_PULSE_TOTAL, pulses);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly steady scenes (votes and temperature hold for a while, so the
    // hold-offs and the buzzer train get to play out) with noisy beats,
    // time jumps and arbitrary field values mixed in.
    task automatic random_passes(input int count, input int pause_at);
        int roll, light, smoke, raw;
        logic present;
        for (int i = 0; i < count; i++) begin
            if (scene_left == 0) begin
                scene_left  = $urandom_range(8, 40);
                scene_light = $urandom_range(0, 20);
                scene_smoke = $urandom_range(0, 10);
                scene_temp  = int'($urandom_range(0, 2880)) - 880;
            end
            scene_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                clock_ms = $urandom;                       // arbitrary jump, maybe backwards
            else if (roll < 8)
                clock_ms = clock_ms + $urandom_range(300, 6000);
            else
                clock_ms = clock_ms + $urandom_range(0, 250);
            light   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : scene_light;
            smoke   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : scene_smoke;
            raw     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                  : scene_temp + $urandom_range(0, 32) - 16;
            present = ($urandom_range(0, 19) != 0);
            // at pass pause_at, if given, the sender waits out everything in flight
            if (i == pause_at) drain_results();
            send(pass_beat(clock_ms, light, smoke, raw, present));
        end
    endtask

    initial begin : stimulus
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset register values. From 2300 ms on, passes are just over 2 s
        // apart so each one takes a temperature sample across the validity edges.
        send(pass_beat(0,     31, 15, 0,     1'b1)); // too soon after reset: no evaluation
        send(pass_beat(299,   20, 10, 100,   1'b1)); // one ms short of the period
        send(pass_beat(300,   31, 15, -880,  1'b1)); // votes above totals clamp
        send(pass_beat(2300,  31, 15, -880,  1'b1)); // coldest valid sample
        send(pass_beat(4301,  0,  0,  -881,  1'b1)); // just below range
        send(pass_beat(6302,  20, 10, 2000,  1'b1)); // hottest valid sample, heat
        send(pass_beat(8303,  20, 10, 2001,  1'b1)); // just above range
        send(pass_beat(10304, 21, 11, 2047,  1'b1)); // max raw code
        send(pass_beat(12305, 5,  7,  -2048, 1'b1)); // min raw code, votes at threshold
        send(pass_beat(14306, 4,  6,  1500,  1'b0)); // sensor not answering
        send(pass_beat(16307, 31, 15, 1500,  1'b1));
        // 100 ms steps to watch the buzzer pulse train run
        for (int k = 1; k <= 12; k++)
            send(pass_beat(32'(16307 + 100 * k), 31, 15, 1500, 1'b1));
        clock_ms = 32'(16307 + 1200);
        drain_results();

        // Low extremes: everything trips at once, zero pulse total.
        program_regs(-2048, 1023, 0, 0, 0, 0, 0, 0);
        random_passes(90, -1);
        drain_results();

        // High extremes: longest hold-offs, longest train.
        program_regs(2047, 0, 20, 10, 65535, 65535, 65535, 15);
        random_passes(80, -1);
        drain_results();

        // No idling on either side; the result side then stalls long
        // enough for the block to fill and push back on its input.
        feed_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        hold_pending = 1'b1;
        program_regs($urandom_range(0, 1500), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     $urandom_range(0, 2000), $urandom_range(0, 2000),
                     $urandom_range(0, 3000), $urandom_range(1, 15));
        random_passes(96, -1);
        drain_results();

        // Time runs across the 32-bit wrap.
        feed_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        clock_ms = 32'hFFFF_F000;
        program_regs($urandom_range(0, 1500), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     $urandom_range(0, 3000), $urandom_range(0, 3000),
                     $urandom_range(0, 5000), $urandom_range(1, 15));
        random_passes(96, -1);
        drain_results();

        // Sender flat out against a random receiver plus one more long hold.
        feed_gaps_on = 1'b0;
        hold_pending = 1'b1;
        program_regs($urandom_range(0, 1500), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     $urandom_range(0, 3000), $urandom_range(0, 3000),
                     $urandom_range(0, 5000), $urandom_range(1, 15));
        random_passes(96, -1);
        drain_results();

        // Sender pauses midway until the block is empty.
        feed_gaps_on = 1'b1;
        program_regs($urandom_range(0, 1500), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     $urandom_range(0, 4000), $urandom_range(0, 4000),
                     $urandom_range(0, 6000), $urandom_range(1, 15));
        random_passes(96, 48);
        drain_results();

        program_regs($urandom_range(0, 1500), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     $urandom_range(0, 4000), $urandom_range(0, 4000),
                     $urandom_range(0, 6000), $urandom_range(1, 15));
        random_passes(96, -1);
        drain_results();

        // wait on to catch any stray beat
        repeat (10) @(negedge aclk);

        $display("Sent %0d loop passes under %0d register settings, time wrap included;",
                 passes_sent, settings_used);
        $display("checked %0d result beats, %0d with fire up, %0d after a finished train.",
                 chk_results, chk_fire, chk_train);
        if (chk_pending != 0)
            $display("%0d predicted result beats never arrived", chk_pending);
        if (chk_mismatches == 0 && chk_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
